>>> sv/sdfvb_pkg.sv
// sdfvb_pkg: shared types and constants of the voxel brush update pipeline
// no dependencies; used by sdfvb_isqrt, sdfvb_div, sdf_voxel_brush_update and tb_top
`timescale 1ns / 1ps

package sdfvb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_RADIUS     = 3'd3;
  localparam logic [2:0] REG_STRENGTH   = 3'd4;
  localparam logic [2:0] REG_MODE       = 3'd5;
  localparam logic [2:0] REG_PROFILE    = 3'd6;
  localparam logic [2:0] REG_HAS_ORIG   = 3'd7;

  typedef enum logic [1:0] {
    KIND_CARVE  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_SMOOTH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FALL_CONST  = 2'd0,
    FALL_LINEAR = 2'd1,
    FALL_SMOOTH = 2'd2,
    FALL_SHARP  = 2'd3
  } fall_t;

  // square root of a 62 bit radicand, one result bit per stage
  localparam int SQ_WIDTH = 62;
  localparam int SQ_STEPS = 31;
  // t divider operand width (radius scaled by 2^12)
  localparam int DIV_WIDTH = 31;
  // floor(2^32 / 15) for the divide by sixty
  localparam logic [31:0] RECIP_15 = 32'h1111_1111;

  // per-request data that rides along the pipeline
  typedef struct packed {
    logic                  pass;
    logic                  cube;
    kind_t                 kind;
    fall_t                 fall;
    logic signed [15:0]    cur;
    logic signed [15:0]    orig;
    logic signed [19:0]    diff;
    logic [DIV_WIDTH-1:0]  m_scaled;
  } side_t;

endpackage

>>> sv/sdfvb_isqrt.sv
// sdfvb_isqrt: pipelined integer square root, one result bit per stage
// depends on sdfvb_pkg
`timescale 1ns / 1ps

module sdfvb_isqrt
  import sdfvb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [SQ_WIDTH-1:0]  in_n,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [SQ_STEPS-1:0]  out_root,
  output side_t                out_side
);

  logic [SQ_WIDTH-1:0] n_s   [0:SQ_STEPS];
  logic [SQ_WIDTH-1:0] res_s [0:SQ_STEPS];
  side_t               side_s[0:SQ_STEPS];
  logic                v_s   [0:SQ_STEPS];

  assign n_s[0]    = in_n;
  assign res_s[0]  = '0;
  assign side_s[0] = in_side;
  assign v_s[0]    = in_valid;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_WIDTH-1:0] BIT = SQ_WIDTH'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_WIDTH-1:0] trial;
    assign trial = res_s[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
      side_s[k+1] <= side_s[k];
      if (n_s[k] >= trial) begin
        n_s[k+1]   <= n_s[k] - trial;
        res_s[k+1] <= (res_s[k] >> 1) + BIT;
      end else begin
        n_s[k+1]   <= n_s[k];
        res_s[k+1] <= res_s[k] >> 1;
      end
    end
  end

  assign out_valid = v_s[SQ_STEPS];
  assign out_root  = res_s[SQ_STEPS][SQ_STEPS-1:0];
  assign out_side  = side_s[SQ_STEPS];

endmodule

>>> sv/sdfvb_div.sv
// sdfvb_div: pipelined restoring divider for the normalized distance t
// depends on sdfvb_pkg; num must be below den, quotient has QB bits
`timescale 1ns / 1ps

module sdfvb_div
  import sdfvb_pkg::*;
#(
  parameter int QB = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DIV_WIDTH-1:0]  in_num,
  input  logic [DIV_WIDTH-1:0]  den,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic [QB-1:0]         out_q,
  output side_t                 out_side
);

  logic [DIV_WIDTH-1:0] rem_s [0:QB];
  logic [QB-1:0]        q_s   [0:QB];
  side_t                side_s[0:QB];
  logic                 v_s   [0:QB];

  assign rem_s[0]  = in_num;
  assign q_s[0]    = '0;
  assign side_s[0] = in_side;
  assign v_s[0]    = in_valid;

  // den comes from a config register; the user must keep it stable while requests are in flight (not enforced here)
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DIV_WIDTH:0] r2;
    assign r2 = {rem_s[k], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
      side_s[k+1] <= side_s[k];
      if (r2 >= {1'b0, den}) begin
        rem_s[k+1] <= DIV_WIDTH'(r2 - {1'b0, den});
        q_s[k+1]   <= {q_s[k][QB-2:0], 1'b1};
      end else begin
        rem_s[k+1] <= r2[DIV_WIDTH-1:0];
        q_s[k+1]   <= {q_s[k][QB-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_s[QB];
  assign out_q     = q_s[QB];
  assign out_side  = side_s[QB];

endmodule

>>> sv/sdf_voxel_brush_update.sv
// sdf_voxel_brush_update: voxel brush (carve, fill, smooth) on a distance field
// depends on sdfvb_pkg, sdfvb_isqrt, sdfvb_div
// done strobes once a request has passed the input stages, the 31 square-root stages,
//   the FRAC_BITS divider stages and the falloff, divide and output stages
// throughput: one request per cycle, busy stays low; results cannot be stalled
// reset: synchronous, clears the pipeline and loads the register defaults
`timescale 1ns / 1ps

module sdf_voxel_brush_update
  import sdfvb_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] pos_x,
  input  logic signed [19:0] pos_y,
  input  logic signed [19:0] pos_z,
  input  logic signed [15:0] current_sdf,
  input  logic signed [15:0] original_sdf,
  input  logic               interior,
  input  logic signed [15:0] nbr_x_minus,
  input  logic signed [15:0] nbr_x_plus,
  input  logic signed [15:0] nbr_y_minus,
  input  logic signed [15:0] nbr_y_plus,
  input  logic signed [15:0] nbr_z_minus,
  input  logic signed [15:0] nbr_z_plus,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] new_sdf,
  output logic               touched
);

  localparam int F      = FRAC_BITS;
  localparam int ONE_I  = 1 << F;
  localparam int LIM_I  = ((10 << F) > 32767) ? 32767 : (10 << F);
  localparam int LAT    = 44 + F;

  // ---------------- configuration ----------------
  logic signed [19:0] center_x, center_y, center_z;
  logic [18:0]        radius;
  logic [15:0]        strength;
  logic [2:0]         mode_code;
  logic [2:0]         profile_code;
  logic               has_original;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      radius       <= 19'd256;
      strength     <= 16'd256;
      mode_code    <= '0;
      profile_code <= '0;
      has_original <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x     <= cfg_data;
        REG_CENTER_Y: center_y     <= cfg_data;
        REG_CENTER_Z: center_z     <= cfg_data;
        REG_RADIUS:   radius       <= cfg_data[18:0];
        REG_STRENGTH: strength     <= cfg_data[15:0];
        REG_MODE:     mode_code    <= cfg_data[2:0];
        REG_PROFILE:  profile_code <= cfg_data[2:0];
        REG_HAS_ORIG: has_original <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [18:0] r_eff;
  logic [37:0] rr;
  assign r_eff = (radius == '0) ? 19'd1 : radius;

  always_ff @(posedge clk) begin
    rr <= r_eff * r_eff;
  end

  kind_t kind0;
  logic  pass0;

  always_comb begin
    kind0 = kind_t'(mode_code[1:0]);
    if (mode_code[2]) begin
      case (kind0)
        KIND_CARVE: kind0 = KIND_FILL;
        KIND_FILL:  kind0 = KIND_CARVE;
        default:    kind0 = kind0;
      endcase
    end
    pass0 = (kind0 == KIND_NONE)
         || (kind0 != KIND_SMOOTH && has_original && original_sdf > 16'sd0)
         || (kind0 == KIND_SMOOTH && !interior);
  end

  // ---------------- stage 1: offsets, pair sums ----------------
  logic               v1;
  logic signed [20:0] dx1, dy1, dz1;
  logic signed [16:0] sx1, sy1, sz1;
  logic signed [18:0] cur6_1;
  logic signed [15:0] cur1, orig1;
  logic               pass1, cube1;
  kind_t              kind1;
  fall_t              fall1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    dx1    <= 21'(pos_x) - 21'(center_x);
    dy1    <= 21'(pos_y) - 21'(center_y);
    dz1    <= 21'(pos_z) - 21'(center_z);
    sx1    <= 17'(nbr_x_minus) + 17'(nbr_x_plus);
    sy1    <= 17'(nbr_y_minus) + 17'(nbr_y_plus);
    sz1    <= 17'(nbr_z_minus) + 17'(nbr_z_plus);
    cur6_1 <= (19'(current_sdf) <<< 2) + (19'(current_sdf) <<< 1);
    cur1   <= current_sdf;
    orig1  <= original_sdf;
    pass1  <= pass0;
    cube1  <= profile_code[0];
    kind1  <= kind0;
    fall1  <= fall_t'(profile_code[2:1]);
  end

  // ---------------- stage 2: magnitudes, neighbour difference ----------------
  logic               v2;
  logic [20:0]        ax2, ay2, az2;
  logic signed [19:0] diff2;
  logic signed [15:0] cur2, orig2;
  logic               pass2, cube2;
  kind_t              kind2;
  fall_t              fall2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ax2   <= dx1[20] ? 21'(-dx1) : 21'(dx1);
    ay2   <= dy1[20] ? 21'(-dy1) : 21'(dy1);
    az2   <= dz1[20] ? 21'(-dz1) : 21'(dz1);
    diff2 <= 20'(sx1) + 20'(sy1) + 20'(sz1) - 20'(cur6_1);
    cur2  <= cur1;
    orig2 <= orig1;
    pass2 <= pass1;
    cube2 <= cube1;
    kind2 <= kind1;
    fall2 <= fall1;
  end

  // ---------------- stage 3: squares, largest axis ----------------
  logic               v3;
  logic [41:0]        qx3, qy3, qz3;
  logic [20:0]        m3;
  logic signed [19:0] diff3;
  logic signed [15:0] cur3, orig3;
  logic               pass3, cube3;
  kind_t              kind3;
  fall_t              fall3;
  logic [20:0]        mxy;

  assign mxy = (ay2 > ax2) ? ay2 : ax2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    qx3   <= ax2 * ax2;
    qy3   <= ay2 * ay2;
    qz3   <= az2 * az2;
    m3    <= (az2 > mxy) ? az2 : mxy;
    diff3 <= diff2;
    cur3  <= cur2;
    orig3 <= orig2;
    pass3 <= pass2;
    cube3 <= cube2;
    kind3 <= kind2;
    fall3 <= fall2;
  end

  // ---------------- stage 4: inside test ----------------
  logic        v4;
  logic [61:0] n4;
  side_t       side4;
  logic [43:0] ssum;
  logic        outside;

  assign ssum    = 44'(qx3) + 44'(qy3) + 44'(qz3);
  assign outside = cube3 ? (m3 >= 21'(r_eff)) : (ssum >= 44'(rr));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    // low bits suffice: anything wider is already outside
    n4             <= {ssum[37:0], 24'b0};
    side4.pass     <= pass3 || outside;
    side4.cube     <= cube3;
    side4.kind     <= kind3;
    side4.fall     <= fall3;
    side4.cur      <= cur3;
    side4.orig     <= orig3;
    side4.diff     <= diff3;
    side4.m_scaled <= {m3[18:0], 12'b0};
  end

  // ---------------- root and normalized distance ----------------
  logic                vs;
  logic [SQ_STEPS-1:0] root_s;
  side_t               side_s;

  sdfvb_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_n      (n4),
    .in_side   (side4),
    .out_valid (vs),
    .out_root  (root_s),
    .out_side  (side_s)
  );

  logic [DIV_WIDTH-1:0] div_num;
  logic                 vd;
  logic [F-1:0]         t_d;
  side_t                side_d;

  assign div_num = side_s.cube ? side_s.m_scaled : DIV_WIDTH'(root_s);

  sdfvb_div #(.QB(F)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .in_num    (div_num),
    .den       ({r_eff, 12'b0}),
    .in_side   (side_s),
    .out_valid (vd),
    .out_q     (t_d),
    .out_side  (side_d)
  );

  // ---------------- falloff ----------------
  logic           v5;
  logic [F-1:0]   t5;
  logic [2*F-1:0] tt5;
  side_t          side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= vd;
    end
    t5    <= t_d;
    tt5   <= t_d * t_d;
    side5 <= side_d;
  end

  logic             v6;
  logic [F-1:0]     t6, t2_6;
  logic [2*F+1:0]   p6;
  logic [F+19:0]    tp6;
  side_t            side6;
  logic [F+1:0]     s3;
  logic [F:0]       omt;

  assign s3  = (F+2)'(3 * ONE_I) - ((F+2)'(t5) << 1);
  assign omt = (F+1)'(ONE_I) - (F+1)'(t5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    t6    <= t5;
    t2_6  <= tt5[2*F-1:F];
    p6    <= tt5[2*F-1:F] * s3;
    tp6   <= r_eff * omt;
    side6 <= side5;
  end

  logic        v7;
  logic [F:0]  f7;
  logic [19:0] tgt7;
  side_t       side7;
  logic [F:0]  f_sel;

  always_comb begin
    case (side6.fall)
      FALL_CONST:  f_sel = (F+1)'(ONE_I);
      FALL_LINEAR: f_sel = (F+1)'(ONE_I) - (F+1)'(t6);
      FALL_SMOOTH: f_sel = (F+1)'(ONE_I) - (F+1)'(p6 >> F);
      default:     f_sel = (F+1)'(ONE_I) - (F+1)'(t2_6);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    f7    <= f_sel;
    tgt7  <= 20'(tp6 >> F);
    side7 <= side6;
  end

  logic          v8;
  logic [F+16:0] fs8;
  logic [19:0]   tgt8;
  side_t         side8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    fs8   <= f7 * strength;
    tgt8  <= tgt7;
    side8 <= side7;
  end

  // ---------------- carve / fill result and smooth product ----------------
  logic               v9;
  logic signed [F+37:0] num9;
  logic signed [21:0] cf9;
  side_t              side9;
  logic [16:0]        infl;
  logic signed [21:0] sum_c, dif_f, floor_f, tgt_s;

  assign infl    = 17'(fs8 >> F);
  assign sum_c   = 22'(side8.cur) + $signed({5'b0, infl});
  assign dif_f   = 22'(side8.cur) - $signed({5'b0, infl});
  assign tgt_s   = $signed({2'b0, tgt8});
  assign floor_f = has_original ? 22'(side8.orig) : -$signed(22'(ONE_I));

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    num9 <= side8.diff * $signed({1'b0, fs8});
    if (side8.kind == KIND_CARVE) begin
      cf9 <= (sum_c > tgt_s) ? tgt_s : sum_c;
    end else begin
      cf9 <= (dif_f < floor_f) ? floor_f : dif_f;
    end
    side9 <= side8;
  end

  // ---------------- divide by 60 * one^2, toward zero ----------------
  logic               v10;
  logic [31:0]        b10;
  logic               neg10;
  logic signed [21:0] cf10;
  side_t              side10;
  logic [F+37:0]      mag9;

  assign mag9 = num9[F+37] ? (F+38)'(-num9) : (F+38)'(num9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    // 60 * 2^2F = 15 * 2^(2F+2)
    b10    <= 32'(mag9 >> (2 * F + 2));
    neg10  <= num9[F+37];
    cf10   <= cf9;
    side10 <= side9;
  end

  logic               v11;
  logic [63:0]        prod11;
  logic [31:0]        b11;
  logic               neg11;
  logic signed [21:0] cf11;
  side_t              side11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    prod11 <= b10 * RECIP_15;
    b11    <= b10;
    neg11  <= neg10;
    cf11   <= cf10;
    side11 <= side10;
  end

  logic               v12;
  logic [31:0]        q12;
  logic               neg12;
  logic signed [21:0] cf12;
  side_t              side12;
  logic [31:0]        q0;
  logic [35:0]        rem15;

  assign q0    = prod11[63:32];
  // estimate is low by at most one
  assign rem15 = 36'(b11) - ((36'(q0) << 4) - 36'(q0));

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
    q12    <= (rem15 >= 36'd15) ? q0 + 32'd1 : q0;
    neg12  <= neg11;
    cf12   <= cf11;
    side12 <= side11;
  end

  // ---------------- final select and clamp ----------------
  logic signed [33:0] delta, sm, res, clamped;
  localparam logic signed [33:0] LIM = 34'(LIM_I);

  always_comb begin
    delta = neg12 ? -$signed({2'b0, q12}) : $signed({2'b0, q12});
    sm    = 34'(side12.cur) + delta;
    res   = (side12.kind == KIND_SMOOTH) ? sm : 34'(cf12);
    if (res > LIM) begin
      clamped = LIM;
    end else if (res < -LIM) begin
      clamped = -LIM;
    end else begin
      clamped = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      touched <= 1'b0;
    end else begin
      done    <= v12;
      touched <= v12 && !side12.pass;
    end
    new_sdf <= side12.pass ? side12.cur : clamped[15:0];
  end

  // ---------------- checks ----------------
  a_touch_done: assert property (@(posedge clk) disable iff (rst)
    touched |-> done)
    else $error("touched without done");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    touched |-> (34'(new_sdf) <= LIM && 34'(new_sdf) >= -LIM))
    else $error("written value beyond clamp");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_pass_value: assert property (@(posedge clk) disable iff (rst)
    v12 && side12.pass |=> new_sdf == $past(side12.cur))
    else $error("pass-through value changed");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench of the voxel brush update block
// depends on sdfvb_pkg and sdf_voxel_brush_update; predicts each voxel result in place
`timescale 1ns / 1ps

module tb_top;
  import sdfvb_pkg::*;

  localparam int FB = 8;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint SDF_LIM = 2560;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [19:0] px, py, pz;
    logic signed [15:0] cur, orig;
    logic               inner;
    logic signed [15:0] nb [6];
  } voxel_t;

  typedef struct {
    logic signed [15:0] sdf;
    logic               hit;
  } voxel_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [19:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] current_sdf = '0, original_sdf = '0;
  logic interior = 1'b0;
  logic signed [15:0] nbr_x_minus = '0, nbr_x_plus = '0, nbr_y_minus = '0;
  logic signed [15:0] nbr_y_plus = '0, nbr_z_minus = '0, nbr_z_plus = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic done;
  logic signed [15:0] new_sdf;
  logic touched;

  sdf_voxel_brush_update #(.FRAC_BITS(FB)) i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // brush registers as the block should hold them
  longint br_cx, br_cy, br_cz;
  longint unsigned br_radius, br_strength;
  logic [2:0] br_mode, br_profile;
  logic br_has_orig;

  voxel_out_t pending_q [$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int phases = 0;
  int burst_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits >>= 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic voxel_out_t brush_predict(input voxel_t v);
    voxel_out_t o;
    longint dx, dy, dz, cur, orig, sum6, t, t2, f, res, m, num, infl, target, floorv;
    longint unsigned r, s, rt;
    kind_t kind;
    fall_t fall;
    dx = longint'(v.px) - br_cx;
    dy = longint'(v.py) - br_cy;
    dz = longint'(v.pz) - br_cz;
    cur = v.cur;
    orig = v.orig;
    sum6 = 0;
    for (int i = 0; i < 6; i++) sum6 += longint'(v.nb[i]);
    r = (br_radius == 0) ? 1 : br_radius;
    kind = kind_t'(br_mode[1:0]);
    fall = fall_t'(br_profile[2:1]);
    o.sdf = v.cur;
    o.hit = 1'b0;
    if (br_mode[2]) begin
      if (kind == KIND_CARVE) kind = KIND_FILL;
      else if (kind == KIND_FILL) kind = KIND_CARVE;
    end
    if (kind == KIND_NONE) return o;
    if (kind != KIND_SMOOTH && br_has_orig && orig > 0) return o;
    if (kind == KIND_SMOOTH && !v.inner) return o;
    if (!br_profile[0]) begin
      s = dx * dx + dy * dy + dz * dz;
      if (s >= r * r) return o;
      rt = root64(s << 24);
      t = longint'((rt << FB) / (r << 12));
    end else begin
      m = absl(dx);
      if (absl(dy) > m) m = absl(dy);
      if (absl(dz) > m) m = absl(dz);
      if (longint'(m) >= longint'(r)) return o;
      t = longint'((longint'(m) << FB) / r);
    end
    t2 = (t * t) >>> FB;
    case (fall)
      FALL_CONST:  f = ONE;
      FALL_LINEAR: f = ONE - t;
      FALL_SMOOTH: f = ONE - ((t2 * (3 * ONE - 2 * t)) >>> FB);
      default:     f = ONE - t2;
    endcase
    if (kind == KIND_SMOOTH) begin
      num = (sum6 - 6 * cur) * f * longint'(br_strength);
      res = cur + num / (longint'(60) <<< (2 * FB));
    end else begin
      infl = (f * longint'(br_strength)) >>> FB;
      if (kind == KIND_CARVE) begin
        target = (longint'(r) * (ONE - t)) >>> FB;
        res = cur + infl;
        if (res > target) res = target;
      end else begin
        floorv = br_has_orig ? orig : -ONE;
        res = cur - infl;
        if (res < floorv) res = floorv;
      end
    end
    if (res > SDF_LIM) res = SDF_LIM;
    if (res < -SDF_LIM) res = -SDF_LIM;
    o.sdf = res[15:0];
    o.hit = 1'b1;
    return o;
  endfunction

  // cfg_valid is left high; cfg_close lowers it after a sequence of writes
  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X: br_cx = longint'($signed(val));
      REG_CENTER_Y: br_cy = longint'($signed(val));
      REG_CENTER_Z: br_cz = longint'($signed(val));
      REG_RADIUS:   br_radius = val[18:0];
      REG_STRENGTH: br_strength = val[15:0];
      REG_MODE:     br_mode = val[2:0];
      REG_PROFILE:  br_profile = val[2:0];
      default:      br_has_orig = val[0];
    endcase
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_brush(input longint cx, cy, cz, input longint unsigned rad, str,
                           input logic [2:0] mode, prof, input logic ho);
    // registers change only with the pipeline empty
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_write(REG_CENTER_X, cx[19:0]);
    cfg_write(REG_CENTER_Y, cy[19:0]);
    cfg_write(REG_CENTER_Z, cz[19:0]);
    cfg_write(REG_RADIUS, {1'b0, rad[18:0]});
    cfg_write(REG_STRENGTH, {4'd0, str[15:0]});
    cfg_write(REG_MODE, {17'd0, mode});
    cfg_write(REG_PROFILE, {17'd0, prof});
    cfg_write(REG_HAS_ORIG, {19'd0, ho});
    cfg_close();
    phases++;
  endtask

  // start is left high between back-to-back requests; gaps lower it
  task automatic send_voxel(input voxel_t v, input bit bursty);
    if (bursty && burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    if (bursty) burst_left--;
    pos_x <= v.px; pos_y <= v.py; pos_z <= v.pz;
    current_sdf <= v.cur; original_sdf <= v.orig; interior <= v.inner;
    nbr_x_minus <= v.nb[0]; nbr_x_plus <= v.nb[1]; nbr_y_minus <= v.nb[2];
    nbr_y_plus <= v.nb[3]; nbr_z_minus <= v.nb[4]; nbr_z_plus <= v.nb[5];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(brush_predict(v));
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic voxel_t mk_voxel(input longint x, y, z, cur, orig, input logic inner,
                                      input longint nbv);
    voxel_t v;
    v.px = x[19:0]; v.py = y[19:0]; v.pz = z[19:0];
    v.cur = cur[15:0]; v.orig = orig[15:0]; v.inner = inner;
    for (int i = 0; i < 6; i++) v.nb[i] = nbv[15:0];
    return v;
  endfunction

  function automatic logic [15:0] rand_sdf();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 6000)) - 3000);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic voxel_t rand_voxel();
    voxel_t v;
    longint span, c;
    span = longint'(br_radius) + longint'(br_radius) / 4 + 2;
    for (int a = 0; a < 3; a++) begin
      c = (a == 0) ? br_cx : (a == 1) ? br_cy : br_cz;
      if ($urandom_range(0, 9) == 0)
        c = longint'($signed(20'($urandom())));
      else
        c = c + longint'($urandom_range(0, 32'(2 * span))) - span;
      if (a == 0) v.px = c[19:0];
      else if (a == 1) v.py = c[19:0];
      else v.pz = c[19:0];
    end
    v.cur = rand_sdf();
    v.orig = rand_sdf();
    v.inner = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < 6; i++) v.nb[i] = rand_sdf();
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    voxel_out_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (new_sdf !== e.sdf)
          report($sformatf("new_sdf %0d expected %0d", new_sdf, e.sdf));
        if (touched !== e.hit)
          report($sformatf("touched %0b expected %0b", touched, e.hit));
      end
    end
  end

  task automatic test_reset_defaults();
    send_voxel(mk_voxel(0, 0, 0, 0, 0, 1, 0), 0);
    send_voxel(mk_voxel(128, 0, 0, 2500, 0, 1, 0), 0);
    send_voxel(mk_voxel(256, 0, 0, 5, 0, 1, 0), 0);
    send_voxel(mk_voxel(524287, -524288, 524287, 32767, -32768, 0, 0), 0);
    drain();
  endtask

  task automatic test_carve_fill();
    // carve with original above the surface is skipped
    set_brush(0, 0, 0, 1024, 65535, 3'd0, 3'd2, 1'b1);
    send_voxel(mk_voxel(10, -20, 30, -32768, 100, 1, 0), 0);
    send_voxel(mk_voxel(10, -20, 30, -32768, -100, 1, 0), 0);
    send_voxel(mk_voxel(500, 0, 0, 32767, -32768, 1, 0), 0);
    // fill floors at the original value
    set_brush(-524288, 524287, 0, 2000, 300, 3'd1, 3'd5, 1'b1);
    send_voxel(mk_voxel(-524288, 524287, 0, 50, -40, 1, 0), 0);
    send_voxel(mk_voxel(-523000, 524287, 100, 2000, -2000, 0, 0), 0);
    // fill with no original floors at minus one; swap bit turns carve into fill
    set_brush(0, 0, 0, 1, 65535, 3'd4, 3'd7, 1'b0);
    send_voxel(mk_voxel(0, 0, 0, 100, 500, 1, 0), 0);
    send_voxel(mk_voxel(1, 0, 0, 100, 500, 1, 0), 0);
    drain();
  endtask

  task automatic test_smooth_and_unused();
    set_brush(100, 100, 100, 524287, 65535, 3'd2, 3'd1, 1'b1);
    send_voxel(mk_voxel(-524288, -524288, -524288, 32767, 32767, 1, -32768), 0);
    send_voxel(mk_voxel(100, 100, 100, -32768, 0, 1, 32767), 0);
    send_voxel(mk_voxel(100, 100, 100, 0, 0, 0, 32767), 0);
    send_voxel(mk_voxel(90000, 100, -50000, 7, 0, 1, -7), 0);
    set_brush(0, 0, 0, 4096, 0, 3'd3, 3'd3, 1'b0);
    send_voxel(mk_voxel(0, 0, 0, 1234, 0, 1, 0), 0);
    set_brush(0, 0, 0, 4096, 0, 3'd7, 3'd3, 1'b0);
    send_voxel(mk_voxel(0, 0, 0, 1234, 0, 1, 0), 0);
    // radius zero behaves as one
    set_brush(0, 0, 0, 0, 1000, 3'd0, 3'd0, 1'b0);
    send_voxel(mk_voxel(0, 0, 0, -500, 0, 1, 0), 0);
    send_voxel(mk_voxel(1, 0, 0, -500, 0, 1, 0), 0);
    drain();
  endtask

  task automatic test_random_phases();
    longint cx, cy, cz;
    longint unsigned rad, str;
    for (int p = 0; p < 21; p++) begin
      cx = longint'($signed(20'($urandom())));
      cy = longint'($signed(20'($urandom())));
      cz = longint'($signed(20'($urandom())));
      case ($urandom_range(0, 5))
        0: rad = 1;
        1: rad = 524287;
        2: rad = $urandom_range(1, 524287);
        default: rad = $urandom_range(2, 8000);
      endcase
      case ($urandom_range(0, 4))
        0: str = 0;
        1: str = 65535;
        default: str = $urandom_range(0, 65535);
      endcase
      if (p == 0) begin
        cx = 524287; cy = -524288; cz = 524287;
      end
      set_brush(cx, cy, cz, rad, str, 3'($urandom()), 3'($urandom()), 1'($urandom()));
      for (int k = 0; k < 50; k++) begin
        send_voxel(rand_voxel(), 1);
        // hold off once mid-phase until the pipeline is empty
        if (p == 3 && k == 25) begin
          start <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
          burst_left = 0;
        end
      end
      drain();
    end
  endtask

  initial begin
    br_cx = 0; br_cy = 0; br_cz = 0;
    br_radius = 256; br_strength = 256;
    br_mode = '0; br_profile = '0; br_has_orig = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_carve_fill();
    test_smooth_and_unused();
    test_random_phases();
    $display("sent %0d voxels over %0d brush settings, %0d results checked",
             sent, phases, checked);
    $display("covered carve, fill, smooth, unused type, sphere and cube, all falloffs");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
sv/sdfvb_pkg.sv
sv/sdfvb_isqrt.sv
sv/sdfvb_div.sv
sv/sdf_voxel_brush_update.sv
dv/tb_top.sv
